FILE: rtl/blg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blg_pkg
// Shared widths, the state-of-charge table, register codes and interface
// structs of the battery level gauge.
// ----------------------------------------------------------------------------
package blg_pkg;

   localparam int SAMPLES_PER_READING = 10;
   localparam int ADC_BITS            = 12;
   localparam int TABLE_POINTS        = 12;
   localparam int SEG_W               = $clog2(TABLE_POINTS);

   localparam int SAMPLE_W   = 13;
   localparam int SUM_W      = 17;
   localparam int COUNT_W    = 4;
   localparam int MV_W       = 16;
   localparam int PCT_W      = 7;
   localparam int REF_W      = 12;
   localparam int GAIN_W     = 4;
   localparam int RATIO_W    = 4;
   localparam int DIV_DW     = 24;
   localparam int DIV_VW     = 16;
   localparam int DIV_CNT_W  = $clog2(DIV_DW + 1);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [REF_W-1:0]   REF_MV_RESET        = 12'd600;
   localparam logic [GAIN_W-1:0]  GAIN_INVERSE_RESET  = 4'd6;
   localparam logic [RATIO_W-1:0] DIVIDER_RATIO_RESET = 4'd3;

   // Voltage/percent points, falling in voltage.
   localparam logic [MV_W-1:0] TABLE_MV [TABLE_POINTS] = '{
      16'd4200, 16'd4160, 16'd4090, 16'd4030, 16'd3890, 16'd3830,
      16'd3680, 16'd3660, 16'd3480, 16'd3420, 16'd3150, 16'd0
   };
   localparam logic [PCT_W-1:0] TABLE_PCT [TABLE_POINTS] = '{
      7'd100, 7'd99, 7'd91, 7'd78, 7'd63, 7'd53,
      7'd36,  7'd35, 7'd14, 7'd11, 7'd1,  7'd0
   };
   localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_MV        = 2'd0,
      CSR_GAIN_INVERSE  = 2'd1,
      CSR_DIVIDER_RATIO = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [REF_W-1:0]   ref_mv;
      logic [GAIN_W-1:0]  gain_inverse;
      logic [RATIO_W-1:0] divider_ratio;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef struct packed {
      logic full;
      logic valid;
   } fifo_status_type;

endpackage

FILE: rtl/blg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blg_front
// Accumulates samples and hands each completed reading sum to the queue.
// ----------------------------------------------------------------------------
module blg_front #(
   parameter int SAMPLES_PER_READING = blg_pkg::SAMPLES_PER_READING
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic signed [blg_pkg::SAMPLE_W-1:0] sample,
   input  logic                               queue_full,
   output logic                               push,
   output logic signed [blg_pkg::SUM_W-1:0]    push_sum
);

   logic signed [blg_pkg::SUM_W-1:0]   sum_ff, sum_in, sum_nx;
   logic        [blg_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                               accept, last;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign last       = count_ff == blg_pkg::COUNT_W'(SAMPLES_PER_READING - 1);
   assign sum_nx     = sum_ff + blg_pkg::SUM_W'(sample);
   assign push       = accept && last;
   assign push_sum   = sum_nx;

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         if (last) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_nx;
            count_in = count_ff + blg_pkg::COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/blg_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blg_fifo
// Two-entry queue of reading sums between front and back.
// ----------------------------------------------------------------------------
module blg_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic signed [blg_pkg::SUM_W-1:0] push_sum,
   input  logic                            pop,
   output blg_pkg::fifo_status_type         status,
   output logic signed [blg_pkg::SUM_W-1:0] pop_sum
);

   logic signed [blg_pkg::SUM_W-1:0] mem_ff [2];
   logic                             wr_ptr_ff, wr_ptr_in;
   logic                             rd_ptr_ff, rd_ptr_in;
   logic [1:0]                       count_ff, count_in;
   logic                             do_push, do_pop;

   assign status.full  = count_ff == 2'd2;
   assign status.valid = count_ff != 2'd0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign pop_sum      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/blg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module blg_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [blg_pkg::DIV_DW-1:0]  dividend,
   input  logic [blg_pkg::DIV_VW-1:0]  divisor,
   output blg_pkg::div_status_type      status,
   output logic [blg_pkg::DIV_DW-1:0]  quotient
);

   logic [blg_pkg::DIV_DW-1:0]    quo_ff, quo_in;
   logic [blg_pkg::DIV_VW-1:0]    rem_ff, rem_in;
   logic [blg_pkg::DIV_VW-1:0]    dsr_ff, dsr_in;
   logic [blg_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [blg_pkg::DIV_VW:0]      trial;
   logic                          ge;

   assign trial       = {rem_ff, quo_ff[blg_pkg::DIV_DW-1]};
   assign ge          = trial >= {1'b0, dsr_ff};
   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = blg_pkg::DIV_CNT_W'(blg_pkg::DIV_DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? blg_pkg::DIV_VW'(trial - {1'b0, dsr_ff})
                     : trial[blg_pkg::DIV_VW-1:0];
         quo_in = {quo_ff[blg_pkg::DIV_DW-2:0], ge};
         cnt_in = cnt_ff - blg_pkg::DIV_CNT_W'(1);
         if (cnt_ff == blg_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

FILE: rtl/blg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blg_back
// Turns a reading sum into battery millivolts and an interpolated charge.
// ----------------------------------------------------------------------------
module blg_back #(
   parameter int SAMPLES_PER_READING = blg_pkg::SAMPLES_PER_READING,
   parameter int ADC_BITS            = blg_pkg::ADC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  blg_pkg::cfg_type                    cfg,
   input  blg_pkg::fifo_status_type            queue,
   input  logic signed [blg_pkg::SUM_W-1:0]    pop_sum,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [blg_pkg::MV_W-1:0]           battery_mv,
   output logic [blg_pkg::PCT_W-1:0]          charge_percent,
   output logic                               above_table
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_AVG    = 9'b000000010,
      ST_MUL1   = 9'b000000100,
      ST_MUL2   = 9'b000001000,
      ST_MUL3   = 9'b000010000,
      ST_SEARCH = 9'b000100000,
      ST_INTERP = 9'b001000000,
      ST_DROP   = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;

   localparam int SEG_W = blg_pkg::SEG_W;
   localparam int MV_W  = blg_pkg::MV_W;
   localparam int PCT_W = blg_pkg::PCT_W;
   localparam int DW    = blg_pkg::DIV_DW;
   localparam int NUM_W = MV_W + PCT_W;

   // average by reciprocal multiply, exact for any 16-bit positive sum
   localparam int     AVG_SHIFT  = 20;
   localparam int     AVG_PROD_W = AVG_SHIFT + 17;
   localparam longint AVG_RECIP  = (longint'(1) << AVG_SHIFT) / SAMPLES_PER_READING + 1;

   state_type                 state_ff, state_in;
   logic [15:0]               avg_ff, avg_in;
   logic [31:0]               prod_ff, prod_in;
   logic [MV_W-1:0]           batt_ff, batt_in;
   logic [PCT_W-1:0]          pct_ff, pct_in;
   logic                      above_ff, above_in;
   logic [SEG_W-1:0]          seg_ff, seg_in;
   logic [DW-1:0]             num_ff, num_in;
   logic [MV_W-1:0]           dv_ff, dv_in;
   logic [PCT_W-1:0]          ph_ff, ph_in;

   logic                      div_start;
   logic [DW-1:0]             div_dividend;
   logic [blg_pkg::DIV_VW-1:0] div_divisor;
   blg_pkg::div_status_type   div_status;
   logic [DW-1:0]             div_quotient;

   logic [AVG_PROD_W-1:0]     avg_prod;
   logic [31:0]               shifted;
   logic [35:0]               wide;
   logic [SEG_W-1:0]          seg_nx;
   logic [MV_W-1:0]           vh, vl, dv;
   logic [PCT_W-1:0]          ph, pl, dp;
   logic [NUM_W-1:0]          num;
   logic                      in_seg;

   blg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign avg_prod = AVG_PROD_W'(avg_ff) * AVG_PROD_W'(AVG_RECIP);
   assign shifted  = prod_ff >> ADC_BITS;
   assign wide     = 36'(shifted) * 36'(cfg.divider_ratio);
   assign seg_nx   = seg_ff + SEG_W'(1);
   assign vh       = blg_pkg::TABLE_MV[seg_ff];
   assign vl       = blg_pkg::TABLE_MV[seg_nx];
   assign ph       = blg_pkg::TABLE_PCT[seg_ff];
   assign pl       = blg_pkg::TABLE_PCT[seg_nx];
   assign dv       = vh - vl;
   assign dp       = (ph >= pl) ? ph - pl : '0;
   assign in_seg   = (vh >= batt_ff) && (batt_ff >= vl);
   assign num      = NUM_W'(vh - batt_ff) * NUM_W'(dp);

   assign pop            = (state_ff == ST_IDLE) && queue.valid;
   assign rsp_tvalid     = state_ff == ST_OUT;
   assign battery_mv     = batt_ff;
   assign charge_percent = pct_ff;
   assign above_table    = above_ff;

   always_comb begin
      state_in     = state_ff;
      avg_in       = avg_ff;
      prod_in      = prod_ff;
      batt_in      = batt_ff;
      pct_in       = pct_ff;
      above_in     = above_ff;
      seg_in       = seg_ff;
      num_in       = num_ff;
      dv_in        = dv_ff;
      ph_in        = ph_ff;
      div_start    = 1'b0;
      div_dividend = num_ff + DW'(dv_ff) - DW'(1);
      div_divisor  = dv_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (queue.valid) begin
               above_in = 1'b0;
               seg_in   = '0;
               // non-positive sums give an average of zero or less
               if (!pop_sum[blg_pkg::SUM_W-1] && (pop_sum != '0)) begin
                  avg_in   = pop_sum[15:0];
                  state_in = ST_AVG;
               end else begin
                  batt_in  = '0;
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_AVG: begin
            avg_in   = avg_prod[AVG_SHIFT +: 16];
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            prod_in  = 32'(avg_ff) * 32'(cfg.ref_mv);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in  = 32'(prod_ff[27:0]) * 32'(cfg.gain_inverse);
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            batt_in  = (|wide[35:MV_W]) ? '1 : wide[MV_W-1:0];
            seg_in   = '0;
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (batt_ff > blg_pkg::TABLE_MV[0]) begin
               above_in = 1'b1;
               pct_in   = blg_pkg::PCT_FULL;
               state_in = ST_OUT;
            end else if (in_seg) begin
               if (dv == '0) begin
                  pct_in   = ph;
                  state_in = ST_OUT;
               end else begin
                  num_in   = DW'(num);
                  dv_in    = dv;
                  ph_in    = ph;
                  state_in = ST_INTERP;
               end
            end else if (seg_ff == SEG_W'(blg_pkg::TABLE_POINTS - 2)) begin
               pct_in   = '0;
               state_in = ST_OUT;
            end else begin
               seg_in = seg_nx;
            end
         end
         ST_INTERP: begin
            // ceiling of num / dv
            div_start = 1'b1;
            state_in  = ST_DROP;
         end
         ST_DROP: begin
            if (div_status.done) begin
               pct_in   = (div_quotient > DW'(ph_ff)) ? '0
                                                      : ph_ff - div_quotient[PCT_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      avg_ff   <= avg_in;
      prod_ff  <= prod_in;
      batt_ff  <= batt_in;
      pct_ff   <= pct_in;
      above_ff <= above_in;
      seg_ff   <= seg_in;
      num_ff   <= num_in;
      dv_ff    <= dv_in;
      ph_ff    <= ph_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/battery_level_gauge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_gauge
// Averages ADC samples into battery millivolts and a state-of-charge percent.
// ----------------------------------------------------------------------------
// channel   dir  handshake               contents
// req_      in   req_tvalid/req_tready   one ADC sample
// rsp_      out  rsp_tvalid/rsp_tready   one reading per SAMPLES_PER_READING words
// csr_      in   csr_valid/csr_ready     register index and write data
//
// The front takes one sample word a cycle while the two-entry queue has room.
// Each reading passes through the back: a reciprocal multiply for the
// average, multiplies by the reference, gain inverse and divider ratio, up to
// 11 table steps and a 24-step divider for the interpolation.
// Reset is synchronous and restores the register defaults and empty state.
// A held result stalls only the back; the front keeps summing until the
// queue fills.
// ----------------------------------------------------------------------------
module battery_level_gauge #(
   parameter int SAMPLES_PER_READING = blg_pkg::SAMPLES_PER_READING,
   parameter int ADC_BITS            = blg_pkg::ADC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // [12:0] adc_sample
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] battery_mv, [22:16] charge_percent, [23] above_table
   output logic [23:0]                       rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [blg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [blg_pkg::CSR_DATA_W-1:0]    csr_data
);

   blg_pkg::cfg_type                  cfg_ff, cfg_in;
   blg_pkg::fifo_status_type          queue;
   logic                              push, pop;
   logic signed [blg_pkg::SUM_W-1:0]  push_sum, pop_sum;
   logic [blg_pkg::MV_W-1:0]          battery_mv;
   logic [blg_pkg::PCT_W-1:0]         charge_percent;
   logic                              above_table;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {above_table, charge_percent, battery_mv};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (blg_pkg::csr_index_type'(csr_index))
            blg_pkg::CSR_REF_MV:        cfg_in.ref_mv        = csr_data;
            blg_pkg::CSR_GAIN_INVERSE:  cfg_in.gain_inverse  = csr_data[blg_pkg::GAIN_W-1:0];
            blg_pkg::CSR_DIVIDER_RATIO: cfg_in.divider_ratio = csr_data[blg_pkg::RATIO_W-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_mv        <= blg_pkg::REF_MV_RESET;
         cfg_ff.gain_inverse  <= blg_pkg::GAIN_INVERSE_RESET;
         cfg_ff.divider_ratio <= blg_pkg::DIVIDER_RATIO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   blg_front #(
      .SAMPLES_PER_READING (SAMPLES_PER_READING)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sample     (signed'(req_tdata[blg_pkg::SAMPLE_W-1:0])),
      .queue_full (queue.full),
      .push       (push),
      .push_sum   (push_sum)
   );

   blg_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_sum (push_sum),
      .pop      (pop),
      .status   (queue),
      .pop_sum  (pop_sum)
   );

   blg_back #(
      .SAMPLES_PER_READING (SAMPLES_PER_READING),
      .ADC_BITS            (ADC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .queue          (queue),
      .pop_sum        (pop_sum),
      .pop            (pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .battery_mv     (battery_mv),
      .charge_percent (charge_percent),
      .above_table    (above_table)
   );

`ifndef SYNTHESIS
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[22:16] <= 7'd100))
      else $error("charge percent above 100");

   a_above_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[23]) |->
         ((rsp_tdata[22:16] == 7'd100) && (rsp_tdata[15:0] > 16'd4200)))
      else $error("above_table without full charge over top point");

   a_zero_mv: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[15:0] == 16'd0)) |->
         ((rsp_tdata[22:16] == 7'd0) && !rsp_tdata[23]))
      else $error("zero millivolts with non-zero charge");
`endif

endmodule

FILE: test/tb_battery_level_gauge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_level_gauge
// Self-checking bench for the battery level gauge. A directed table of whole
// readings covers the register extremes, zero registers, saturation and the
// top of the charge table. Random phases under several register settings
// follow. Every reading is compared field by field with an in-bench
// prediction. The sender runs in bursts with gaps and the receiver stalls in
// changing patterns.
// ----------------------------------------------------------------------------
module tb_battery_level_gauge;

   localparam int SETTLE_CYCLES = 100;
   localparam int PHASES        = 10;
   localparam int PHASE_WORDS   = 120;

   typedef struct {
      logic [blg_pkg::MV_W-1:0]  mv;
      logic [blg_pkg::PCT_W-1:0] pct;
      logic                      above;
   } reading_type;

   typedef struct {
      int rmv;
      int gain;
      int ratio;
      int sample;
      bit typed;
      int mv;
      int pct;
      int above;
   } gauge_row_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [15:0]                    req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [23:0]                    rsp_tdata;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [blg_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [blg_pkg::CSR_DATA_W-1:0] csr_data   = '0;

   reading_type pending_readings[$];
   int          error_count = 0;

   int cfg_rmv   = int'(blg_pkg::REF_MV_RESET);
   int cfg_gain  = int'(blg_pkg::GAIN_INVERSE_RESET);
   int cfg_ratio = int'(blg_pkg::DIVIDER_RATIO_RESET);
   int acc_sum   = 0;
   int acc_count = 0;
   int burst_left = 0;

   int          stall_mode = 0;
   int          stall_left = 0;
   reading_type due_reading;

   battery_level_gauge u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int soc_percent(input int mv, output bit above);
      int vh, vl, ph, pl, dv, dp, num, drop;
      above = 1'b0;
      if (mv > int'(blg_pkg::TABLE_MV[0])) begin
         above = 1'b1;
         return int'(blg_pkg::PCT_FULL);
      end
      for (int i = 0; i + 1 < blg_pkg::TABLE_POINTS; i++) begin
         vh = int'(blg_pkg::TABLE_MV[i]);
         vl = int'(blg_pkg::TABLE_MV[i+1]);
         if (vh >= mv && mv >= vl) begin
            ph = int'(blg_pkg::TABLE_PCT[i]);
            pl = int'(blg_pkg::TABLE_PCT[i+1]);
            dv = vh - vl;
            if (dv == 0) return ph;
            dp   = (ph >= pl) ? ph - pl : 0;
            num  = (vh - mv) * dp;
            drop = (num + dv - 1) / dv;
            return (drop > ph) ? 0 : ph - drop;
         end
      end
      return 0;
   endfunction

   // Accumulates one sample; returns 1 with the reading when one completes.
   function automatic bit take_sample(input int s, output reading_type r);
      logic signed [blg_pkg::SAMPLE_W-1:0] v;
      int     avg, pct;
      longint prod, batt;
      bit     above;
      v = s[blg_pkg::SAMPLE_W-1:0];
      acc_sum   += v;
      acc_count += 1;
      if (acc_count < blg_pkg::SAMPLES_PER_READING) return 1'b0;
      avg       = acc_sum / blg_pkg::SAMPLES_PER_READING;
      acc_sum   = 0;
      acc_count = 0;
      prod = longint'(avg) * cfg_rmv * cfg_gain;
      if (prod <= 0) begin
         batt = 0;
      end else begin
         batt = (prod >>> blg_pkg::ADC_BITS) * cfg_ratio;
         if (batt > 65535) batt = 65535;
      end
      pct = soc_percent(int'(batt), above);
      r.mv    = batt[blg_pkg::MV_W-1:0];
      r.pct   = pct[blg_pkg::PCT_W-1:0];
      r.above = above;
      return 1'b1;
   endfunction

   task automatic send_sample(input int s, input bit typed, input reading_type typed_r);
      int          gap;
      reading_type r;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 8);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= 16'(s[blg_pkg::SAMPLE_W-1:0]);
      do @(posedge clock); while (!req_tready);
      if (take_sample(s, r)) pending_readings.push_back(typed ? typed_r : r);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input int rmv, input int gain, input int ratio);
      blg_pkg::csr_index_type order[3];
      int                     vals[3];
      order = '{blg_pkg::CSR_REF_MV, blg_pkg::CSR_GAIN_INVERSE, blg_pkg::CSR_DIVIDER_RATIO};
      vals  = '{rmv, gain, ratio};
      csr_valid <= 1'b1;
      for (int k = 0; k < 3; k++) begin
         csr_index <= order[k];
         if (order[k] == blg_pkg::CSR_REF_MV)
            csr_data <= vals[k][blg_pkg::REF_W-1:0];
         else
            csr_data <= {8'($urandom_range(0, 255)), vals[k][3:0]};
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cfg_rmv   = rmv & 'hFFF;
      cfg_gain  = gain & 'hF;
      cfg_ratio = ratio & 'hF;
   endtask

   // receiver: stall pattern switches between always ready, random and sparse ready
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 300);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 9) == 0);
      endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            $error("unexpected reading: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            due_reading = pending_readings.pop_front();
            if (rsp_tdata[15:0] !== due_reading.mv) begin
               $error("battery_mv: expected %0d, got %0d", due_reading.mv, rsp_tdata[15:0]);
               error_count++;
            end
            if (rsp_tdata[22:16] !== due_reading.pct) begin
               $error("charge_percent: expected %0d, got %0d",
                      due_reading.pct, rsp_tdata[22:16]);
               error_count++;
            end
            if (rsp_tdata[23] !== due_reading.above) begin
               $error("above_table: expected %0d, got %0d", due_reading.above, rsp_tdata[23]);
               error_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      gauge_row_type directed_rows[12];
      reading_type   typed_r;
      reading_type   none_r;
      int            target, base, smp, scale, pick;
      int            rmv, gain, ratio;

      directed_rows = '{
         '{600,  6,  3,  4095,  1, 10797, 100, 1},
         '{600,  6,  3,  -2048, 1, 0,     0,   0},
         '{600,  6,  3,  1234,  0, 0,     0,   0},
         '{4095, 15, 15, 4095,  1, 65535, 100, 1},
         '{0,    6,  3,  4095,  1, 0,     0,   0},
         '{600,  0,  3,  4095,  1, 0,     0,   0},
         '{600,  6,  0,  4095,  1, 0,     0,   0},
         '{2048, 2,  2,  2100,  1, 4200,  100, 0},
         '{2048, 2,  2,  2101,  1, 4202,  100, 1},
         '{2048, 2,  1,  3150,  1, 3150,  1,   0},
         '{2048, 2,  1,  1,     1, 1,     0,   0},
         '{2048, 2,  1,  3700,  0, 0,     0,   0}
      };
      none_r = '{default: '0};
      base   = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].rmv != cfg_rmv || directed_rows[i].gain != cfg_gain ||
             directed_rows[i].ratio != cfg_ratio) begin
            settle();
            write_config(directed_rows[i].rmv, directed_rows[i].gain, directed_rows[i].ratio);
         end
         typed_r.mv    = directed_rows[i].mv[blg_pkg::MV_W-1:0];
         typed_r.pct   = directed_rows[i].pct[blg_pkg::PCT_W-1:0];
         typed_r.above = directed_rows[i].above[0];
         repeat (blg_pkg::SAMPLES_PER_READING)
            send_sample(directed_rows[i].sample, directed_rows[i].typed, typed_r);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       begin rmv = 600;  gain = 6;  ratio = 3;  end
            1:       begin rmv = 4095; gain = 8;  ratio = 15; end
            2:       begin rmv = 1;    gain = 1;  ratio = 1;  end
            3:       begin rmv = 2048; gain = 2;  ratio = 1;  end
            4:       begin rmv = 2048; gain = 2;  ratio = 2;  end
            5:       begin rmv = 4095; gain = 15; ratio = 15; end
            default: begin
               rmv   = $urandom_range(0, 4095);
               gain  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(1, 8);
               ratio = $urandom_range(1, 15);
            end
         endcase
         settle();
         write_config(rmv, gain, ratio);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // aim each reading at a voltage around the charge table
            if (acc_count == 0) begin
               target = $urandom_range(2900, 4500);
               scale  = cfg_rmv * cfg_gain * cfg_ratio;
               base   = (scale == 0) ? int'($urandom_range(0, 4095))
                                     : int'((longint'(target) << blg_pkg::ADC_BITS) / scale);
               if (base > 4095) base = 4095;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               smp = base + int'($urandom_range(0, 16)) - 8;
               if (smp > 4095) smp = 4095;
            end else if (pick < 9) begin
               smp = int'($urandom_range(0, 6143)) - 2048;
            end else begin
               case ($urandom_range(0, 3))
                  0:       smp = -2048;
                  1:       smp = 4095;
                  2:       smp = 0;
                  default: smp = -1;
               endcase
            end
            send_sample(smp, 1'b0, none_r);
         end
      end

      settle();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: sim.f
rtl/blg_pkg.sv
rtl/blg_front.sv
rtl/blg_fifo.sv
rtl/blg_div.sv
rtl/blg_back.sv
rtl/battery_level_gauge.sv
test/tb_battery_level_gauge.sv
